// ===== rtl/spd_pkg.sv =====
// Package for the spectral Poisson divide block: widths, register codes and
// the sin^2 lookup tables built at elaboration. No dependencies.
package spd_pkg;

    // Axis sizes of the transform grid
    localparam int X_SIZE = 128;
    localparam int Y_SIZE = 64;
    localparam int Z_SIZE = 64;

    // Field widths
    localparam int FX_W    = 7;
    localparam int FY_W    = 6;
    localparam int FZ_W    = 6;
    localparam int SMP_W   = 32;
    localparam int CFG_W   = 32;
    localparam int SQ_W    = 17;                 // Q1.16, 0..65536
    localparam int PROD_W  = SQ_W + CFG_W;       // table entry times cell term
    localparam int S_W     = PROD_W + 4;         // sum of three, times four
    localparam int DIV_STEPS = SMP_W;            // one quotient bit per stage

    // Lanes of the divider
    localparam int NUM_LANES = 2;
    localparam int LANE_RE   = 0;
    localparam int LANE_IM   = 1;

    // Saturation limits of the quotient
    localparam logic [SMP_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [SMP_W-1:0] SAT_NEG = 32'h8000_0000;

    // Register map
    localparam int NUM_REGS = 4;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int ADDR_W   = IDX_W + 2;
    localparam logic [CFG_W-1:0] INV_CELL_SQ_RESET  = 32'd10737418;
    localparam logic [CFG_W-1:0] ZERO_THRESH_RESET  = 32'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_INV_X,
        REG_INV_Y,
        REG_INV_Z,
        REG_ZERO_THR
    } reg_idx_t;

    // sin^2 table construction (elaboration only)
    localparam logic [63:0] PI_Q30       = 64'd3373259426;
    localparam int          SERIES_TERMS = 10;
    localparam logic [63:0] SERIES_DEN [1:SERIES_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
          64'd342, 64'd420};
    localparam logic [63:0] SQ_ROUND = 64'd1 << 43;
    localparam logic [63:0] SQ_MAX   = 64'd65536;

    typedef logic [SQ_W-1:0] sinsq_x_t [2**FX_W];
    typedef logic [SQ_W-1:0] sinsq_y_t [2**FY_W];
    typedef logic [SQ_W-1:0] sinsq_z_t [2**FZ_W];

    // Taylor series of sin in Q30, squared and rounded to Q16
    function automatic logic [SQ_W-1:0] sinsq_of_angle(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] sq;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = ((term * x2) >> 30) / SERIES_DEN[k];
            if ((k & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        sq = (sum * sum + SQ_ROUND) >> 44;
        if (sq > SQ_MAX)
            sq = SQ_MAX;
        return sq[SQ_W-1:0];
    endfunction

    // Each table spans every code of its index field; indices fold periodically
    function automatic sinsq_x_t build_sinsq_x();
        sinsq_x_t    t;
        logic [63:0] m;
        for (int i = 0; i < 2**FX_W; i++)
        begin
            m = 64'(i % X_SIZE);
            if (64'(X_SIZE) - m < m)
                m = 64'(X_SIZE) - m;
            t[i] = sinsq_of_angle((PI_Q30 * m) / X_SIZE);
        end
        return t;
    endfunction

    function automatic sinsq_y_t build_sinsq_y();
        sinsq_y_t    t;
        logic [63:0] m;
        for (int i = 0; i < 2**FY_W; i++)
        begin
            m = 64'(i % Y_SIZE);
            if (64'(Y_SIZE) - m < m)
                m = 64'(Y_SIZE) - m;
            t[i] = sinsq_of_angle((PI_Q30 * m) / Y_SIZE);
        end
        return t;
    endfunction

    function automatic sinsq_z_t build_sinsq_z();
        sinsq_z_t    t;
        logic [63:0] m;
        for (int i = 0; i < 2**FZ_W; i++)
        begin
            m = 64'(i % Z_SIZE);
            if (64'(Z_SIZE) - m < m)
                m = 64'(Z_SIZE) - m;
            t[i] = sinsq_of_angle((PI_Q30 * m) / Z_SIZE);
        end
        return t;
    endfunction

    localparam sinsq_x_t SINSQ_X = build_sinsq_x();
    localparam sinsq_y_t SINSQ_Y = build_sinsq_y();
    localparam sinsq_z_t SINSQ_Z = build_sinsq_z();

endpackage

// ===== rtl/spd_in_if.sv =====
// Input stream channel: frequency index and complex sample, valid/ready.
// Depends on spd_pkg for field widths.
interface spd_in_if;
    logic                            valid;
    logic                            ready;
    logic [spd_pkg::FX_W-1:0]        freq_x;
    logic [spd_pkg::FY_W-1:0]        freq_y;
    logic [spd_pkg::FZ_W-1:0]        freq_z;
    logic signed [spd_pkg::SMP_W-1:0] in_real;
    logic signed [spd_pkg::SMP_W-1:0] in_imag;

    modport source (output valid, freq_x, freq_y, freq_z, in_real, in_imag,
                    input ready);
    modport sink   (input valid, freq_x, freq_y, freq_z, in_real, in_imag,
                    output ready);
endinterface

// ===== rtl/spd_out_if.sv =====
// Output stream channel: complex quotient, valid/ready.
// Depends on spd_pkg for field widths.
interface spd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [spd_pkg::SMP_W-1:0] out_real;
    logic signed [spd_pkg::SMP_W-1:0] out_imag;

    modport source (output valid, out_real, out_imag, input ready);
    modport sink   (input valid, out_real, out_imag, output ready);
endinterface

// ===== rtl/spectral_poisson_divide.sv =====
// Pipeline: an accepted word passes 3 front stages, the divider init stage,
//   32 restoring-divide stages with one quotient bit each, and the output stage.
// Throughput: one word per cycle unless stalled; the 32 restoring-divide stages set the depth.
// A stalled output holds the whole pipeline; input ready follows output space.
// Reset (rst_n, async, active low) clears all valid bits and loads the
//   register defaults; data registers carry no reset.
// Depends on spd_pkg, spd_in_if and spd_out_if.
module spectral_poisson_divide (
    input  logic                       clk,
    input  logic                       rst_n,
    spd_in_if.sink                     sample,
    spd_out_if.source                  result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spd_pkg::ADDR_W-1:0] paddr,
    input  logic [spd_pkg::CFG_W-1:0]  pwdata,
    output logic [spd_pkg::CFG_W-1:0]  prdata,
    output logic                       pready
);

    localparam int S_W   = spd_pkg::S_W;
    localparam int SMP_W = spd_pkg::SMP_W;
    localparam int NL    = spd_pkg::NUM_LANES;
    localparam int DS    = spd_pkg::DIV_STEPS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [spd_pkg::CFG_W-1:0] inv_x_reg;
    logic [spd_pkg::CFG_W-1:0] inv_y_reg;
    logic [spd_pkg::CFG_W-1:0] inv_z_reg;
    logic [spd_pkg::CFG_W-1:0] zero_thr_reg;
    spd_pkg::reg_idx_t         reg_idx;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = spd_pkg::reg_idx_t'(paddr[spd_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg    <= spd_pkg::INV_CELL_SQ_RESET;
            inv_y_reg    <= spd_pkg::INV_CELL_SQ_RESET;
            inv_z_reg    <= spd_pkg::INV_CELL_SQ_RESET;
            zero_thr_reg <= spd_pkg::ZERO_THRESH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                spd_pkg::REG_INV_X:    inv_x_reg    <= pwdata;
                spd_pkg::REG_INV_Y:    inv_y_reg    <= pwdata;
                spd_pkg::REG_INV_Z:    inv_z_reg    <= pwdata;
                spd_pkg::REG_ZERO_THR: zero_thr_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            spd_pkg::REG_INV_X:    prdata = inv_x_reg;
            spd_pkg::REG_INV_Y:    prdata = inv_y_reg;
            spd_pkg::REG_INV_Z:    prdata = inv_z_reg;
            spd_pkg::REG_ZERO_THR: prdata = zero_thr_reg;
            default:               prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline advance: whole pipe moves when the output slot is free
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic adv;

    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;

    // ---------------------------------------------------------------
    // Stage 0: sin^2 table lookup
    // ---------------------------------------------------------------
    logic                    v0_reg;
    logic [spd_pkg::SQ_W-1:0] sx0_reg, sy0_reg, sz0_reg;
    logic [SMP_W-1:0]        re0_reg, im0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx0_reg <= spd_pkg::SINSQ_X[sample.freq_x];
            sy0_reg <= spd_pkg::SINSQ_Y[sample.freq_y];
            sz0_reg <= spd_pkg::SINSQ_Z[sample.freq_z];
            re0_reg <= sample.in_real;
            im0_reg <= sample.in_imag;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: per-axis products, sample sign and magnitude
    // ---------------------------------------------------------------
    logic                       v1_reg;
    logic [spd_pkg::PROD_W-1:0] px1_reg, py1_reg, pz1_reg;
    logic                       neg1_reg [NL];
    logic [SMP_W-1:0]           mag1_reg [NL];
    logic [SMP_W-1:0]           smp0 [NL];

    assign smp0[spd_pkg::LANE_RE] = re0_reg;
    assign smp0[spd_pkg::LANE_IM] = im0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px1_reg <= spd_pkg::PROD_W'(sx0_reg) * spd_pkg::PROD_W'(inv_x_reg);
            py1_reg <= spd_pkg::PROD_W'(sy0_reg) * spd_pkg::PROD_W'(inv_y_reg);
            pz1_reg <= spd_pkg::PROD_W'(sz0_reg) * spd_pkg::PROD_W'(inv_z_reg);
            for (int l = 0; l < NL; l++)
            begin
                neg1_reg[l] <= smp0[l][SMP_W-1];
                // two's complement magnitude; most negative maps to 2^31
                mag1_reg[l] <= smp0[l][SMP_W-1] ? (~smp0[l] + 1'b1) : smp0[l];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: eigenvalue sum and zero test
    // ---------------------------------------------------------------
    logic             v2_reg;
    logic [S_W-1:0]   s2_reg;
    logic             zero2_reg;
    logic             neg2_reg [NL];
    logic [SMP_W-1:0] mag2_reg [NL];
    logic [S_W-1:0]   s2_next;

    assign s2_next = (S_W'(px1_reg) + S_W'(py1_reg) + S_W'(pz1_reg)) << 2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg    <= s2_next;
            zero2_reg <= (s2_next <= S_W'({zero_thr_reg, 16'h0000}));
            for (int l = 0; l < NL; l++)
            begin
                neg2_reg[l] <= neg1_reg[l];
                mag2_reg[l] <= mag1_reg[l];
            end
        end
    end

    // ---------------------------------------------------------------
    // Divider: init stage then one restoring step per stage.
    // Remainder stays below S; overflow (mag >= S) means quotient >= 2^32.
    // ---------------------------------------------------------------
    logic             dv_valid_reg [DS+1];
    logic [S_W-1:0]   dv_s_reg     [DS+1];
    logic             dv_zero_reg  [DS+1];
    logic [S_W-1:0]   dv_rem_reg   [NL][DS+1];
    logic [SMP_W-1:0] dv_q_reg     [NL][DS+1];
    logic             dv_neg_reg   [NL][DS+1];
    logic             dv_ovf_reg   [NL][DS+1];

    logic             ovf_init [NL];
    logic [S_W:0]     dbl      [NL][DS];
    logic [S_W:0]     diff     [NL][DS];
    logic             take     [NL][DS];

    // Init stage overflow test
    always_comb
    begin
        for (int l = 0; l < NL; l++)
            ovf_init[l] = (S_W'(mag2_reg[l]) >= s2_reg);
    end

    // Trial subtract feeding step k+1 from the remainder of stage k
    always_comb
    begin
        for (int k = 0; k < DS; k++)
            for (int l = 0; l < NL; l++)
            begin
                dbl[l][k]  = {dv_rem_reg[l][k], 1'b0};
                diff[l][k] = dbl[l][k] - {1'b0, dv_s_reg[k]};
                take[l][k] = (dbl[l][k] >= {1'b0, dv_s_reg[k]});
            end
    end

    // Valid bits of the init and step stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DS; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= v2_reg;
            for (int k = 1; k <= DS; k++)
                dv_valid_reg[k] <= dv_valid_reg[k-1];
        end
    end

    // Init and step stage data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_s_reg[0]    <= s2_reg;
            dv_zero_reg[0] <= zero2_reg;
            for (int l = 0; l < NL; l++)
            begin
                dv_neg_reg[l][0] <= neg2_reg[l];
                dv_ovf_reg[l][0] <= ovf_init[l];
                dv_q_reg[l][0]   <= '0;
                dv_rem_reg[l][0] <= (zero2_reg || ovf_init[l]) ? '0
                                                               : S_W'(mag2_reg[l]);
            end
            for (int k = 1; k <= DS; k++)
            begin
                dv_s_reg[k]    <= dv_s_reg[k-1];
                dv_zero_reg[k] <= dv_zero_reg[k-1];
                for (int l = 0; l < NL; l++)
                begin
                    dv_neg_reg[l][k] <= dv_neg_reg[l][k-1];
                    dv_ovf_reg[l][k] <= dv_ovf_reg[l][k-1];
                    dv_q_reg[l][k]   <= {dv_q_reg[l][k-1][SMP_W-2:0], take[l][k-1]};
                    dv_rem_reg[l][k] <= take[l][k-1] ? diff[l][k-1][S_W-1:0]
                                                     : dbl[l][k-1][S_W-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: sign, saturation, zero forcing
    // ---------------------------------------------------------------
    logic [SMP_W-1:0] res [NL];
    logic [SMP_W-1:0] out_real_reg, out_imag_reg;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (dv_zero_reg[DS])
                res[l] = '0;
            else if (dv_neg_reg[l][DS])
                res[l] = (dv_ovf_reg[l][DS] || dv_q_reg[l][DS] > spd_pkg::SAT_POS)
                         ? spd_pkg::SAT_POS : dv_q_reg[l][DS];
            else
                res[l] = (dv_ovf_reg[l][DS] || dv_q_reg[l][DS] > spd_pkg::SAT_NEG)
                         ? spd_pkg::SAT_NEG : (~dv_q_reg[l][DS] + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid_reg[DS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_real_reg <= res[spd_pkg::LANE_RE];
            out_imag_reg <= res[spd_pkg::LANE_IM];
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_real = out_real_reg;
    assign result.out_imag = out_imag_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A held output word blocks new input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !sample.ready)
        else $error("input accepted while output stalled");

    // Accepted word shows up in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> v0_reg)
        else $error("accepted word lost at stage 0");

    // Divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[DS] |-> (dv_zero_reg[DS] ||
            (dv_rem_reg[spd_pkg::LANE_RE][DS] < dv_s_reg[DS] &&
             dv_rem_reg[spd_pkg::LANE_IM][DS] < dv_s_reg[DS])))
        else $error("divider remainder out of range");

    // Small eigenvalue gives a zero result
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[DS] && dv_zero_reg[DS] && adv |=>
            result.valid && result.out_real == '0 && result.out_imag == '0)
        else $error("zero-threshold word not forced to zero");

endmodule
